// ===== hdl/rcpwm_pkg.sv =====
package rcpwm_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_WIDTH_LIMIT     = 3'd0;
    localparam logic [2:0] REG_STICK_OFFSET    = 3'd1;
    localparam logic [2:0] REG_STICK_GAIN      = 3'd2;
    localparam logic [2:0] REG_THROTTLE_OFFSET = 3'd3;
    localparam logic [2:0] REG_THROTTLE_GAIN   = 3'd4;

    // Configuration reset values. The gains are unsigned Q4.12.
    localparam logic [15:0] WIDTH_LIMIT_RST     = 16'd1000;
    localparam logic [15:0] STICK_OFFSET_RST    = 16'd700;
    localparam logic [15:0] STICK_GAIN_RST      = 16'd12931;
    localparam logic [15:0] THROTTLE_OFFSET_RST = 16'd510;
    localparam logic [15:0] THROTTLE_GAIN_RST   = 16'd8397;

    localparam int Q_SHIFT = 12;

    localparam logic [15:0] POS_MAX = 16'h7FFF;
    localparam logic [15:0] NEG_MAX = 16'h8000;

    // How a channel turns its width into a command value.
    typedef logic [1:0] scale_mode_t;

    localparam scale_mode_t MODE_STICK     = 2'd0;
    localparam scale_mode_t MODE_STICK_NEG = 2'd1;
    localparam scale_mode_t MODE_THROTTLE  = 2'd2;
    localparam scale_mode_t MODE_RAW       = 2'd3;

    function automatic scale_mode_t channel_mode(input logic [2:0] ch);
        scale_mode_t m;
        case (ch)
            3'd2, 3'd3: m = MODE_RAW;
            3'd4:       m = MODE_THROTTLE;
            3'd7:       m = MODE_STICK_NEG;
            default:    m = MODE_STICK;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/rc_pwm_pulse_width_decoder_unit.sv =====
// Throughput: one transaction per cycle while out_ready does not stall the output.
// Four register stages (stage 1, stage 2, stage 3 and output) form a stallable pipeline.
// The per-channel rise, fall and last-good-width registers are read and written in the
// first stage, so back-to-back events on one channel see each other without forwarding.
// Reset (rst_n low, asynchronous) empties the pipeline, clears all per-channel state to
// zero and loads the configuration registers with their default values.
module rc_pwm_pulse_width_decoder_unit
    import rcpwm_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int COUNTER_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         channel,
    input  logic               pin_level,
    input  logic [15:0]        capture_value,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         out_channel,
    output logic               updated,
    output logic [15:0]        pulse_width,
    output logic signed [15:0] scaled_value
);

    // Index width for the per-channel registers, and the capture mask. Captures are
    // stored as 16 bits, so a counter wider than that keeps all 16 bits.
    localparam int IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CAP_BITS = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
    localparam logic [15:0] CAP_MASK = 16'((33'd1 << CAP_BITS) - 33'd1);

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the pipeline is empty,
    // so every stage sees one stable set of values; the block does not enforce this.
    // ------------------------------------------------------------------
    logic [15:0] width_limit_reg;
    logic [15:0] stick_offset_reg;
    logic [15:0] stick_gain_reg;
    logic [15:0] throttle_offset_reg;
    logic [15:0] throttle_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_limit_reg     <= WIDTH_LIMIT_RST;
            stick_offset_reg    <= STICK_OFFSET_RST;
            stick_gain_reg      <= STICK_GAIN_RST;
            throttle_offset_reg <= THROTTLE_OFFSET_RST;
            throttle_gain_reg   <= THROTTLE_GAIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH_LIMIT:     width_limit_reg     <= cfg_data;
                REG_STICK_OFFSET:    stick_offset_reg    <= cfg_data;
                REG_STICK_GAIN:      stick_gain_reg      <= cfg_data;
                REG_THROTTLE_OFFSET: throttle_offset_reg <= cfg_data;
                REG_THROTTLE_GAIN:   throttle_gain_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage moves forward when the stage after
    // it is empty or is itself moving, so a stalled result never blocks
    // the empty stages behind it.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_adv, s2_adv, s3_adv, out_adv;

    assign out_adv  = !out_valid_reg || out_ready;
    assign s3_adv   = !s3_valid_reg || out_adv;
    assign s2_adv   = !s2_valid_reg || s3_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register, per-channel edge times and width check.
    // ------------------------------------------------------------------
    logic [2:0]  s1_channel_reg;
    logic        s1_level_reg;
    logic [15:0] s1_cap_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_channel_reg <= channel;
            s1_level_reg   <= pin_level;
            s1_cap_reg     <= capture_value & CAP_MASK;
        end
    end

    logic [15:0] rise_reg [NUM_CHANNELS];
    logic [15:0] fall_reg [NUM_CHANNELS];
    logic [15:0] good_reg [NUM_CHANNELS];

    logic [IDX_W+2:0] s1_ch_ext;
    logic [IDX_W-1:0] s1_idx;
    logic             s1_present;
    logic [15:0]      s1_rise_new;
    logic [15:0]      s1_fall_new;
    logic [15:0]      s1_raw_width;
    logic [15:0]      s1_good_width;
    logic             s1_ordered;
    logic             s1_updated;
    logic [15:0]      s1_width;
    logic             s1_write;

    always_comb
    begin
        s1_ch_ext     = {{IDX_W{1'b0}}, s1_channel_reg};
        s1_idx        = s1_ch_ext[IDX_W-1:0];
        s1_present    = (s1_ch_ext < (IDX_W+3)'(NUM_CHANNELS));
        s1_rise_new   = s1_level_reg ? s1_cap_reg : rise_reg[s1_idx];
        s1_fall_new   = s1_level_reg ? fall_reg[s1_idx] : s1_cap_reg;
        s1_ordered    = (s1_fall_new >= s1_rise_new);
        s1_raw_width  = s1_fall_new - s1_rise_new;
        // A glitch falls back to the last width that passed the check.
        s1_good_width = (s1_raw_width > width_limit_reg) ? good_reg[s1_idx] : s1_raw_width;
        s1_updated    = s1_present && s1_ordered;
        s1_width      = s1_updated ? s1_good_width : 16'd0;
        s1_write      = s1_valid_reg && s2_adv && s1_present;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rise_reg[i] <= 16'd0;
                fall_reg[i] <= 16'd0;
                good_reg[i] <= 16'd0;
            end
        end
        else if (s1_write)
        begin
            rise_reg[s1_idx] <= s1_rise_new;
            fall_reg[s1_idx] <= s1_fall_new;
            if (s1_ordered)
            begin
                good_reg[s1_idx] <= s1_good_width;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: offset subtraction and the single gain multiply.
    // ------------------------------------------------------------------
    logic [2:0]  s2_channel_reg;
    logic        s2_updated_reg;
    logic [15:0] s2_width_reg;

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_channel_reg <= s1_channel_reg;
            s2_updated_reg <= s1_updated;
            s2_width_reg   <= s1_width;
        end
    end

    scale_mode_t s2_mode;
    logic [15:0] s2_offset;
    logic [15:0] s2_gain;
    logic [16:0] s2_diff;
    logic        s2_negative;
    logic [15:0] s2_mag;
    logic [31:0] s2_product;

    always_comb
    begin
        s2_mode     = channel_mode(s2_channel_reg);
        s2_offset   = (s2_mode == MODE_THROTTLE) ? throttle_offset_reg : stick_offset_reg;
        s2_gain     = (s2_mode == MODE_THROTTLE) ? throttle_gain_reg : stick_gain_reg;
        s2_diff     = {1'b0, s2_width_reg} - {1'b0, s2_offset};
        s2_negative = s2_diff[16];
        // The magnitude of a 17-bit difference of two 16-bit values fits in 16 bits.
        s2_mag      = s2_negative ? 16'(-s2_diff) : s2_diff[15:0];
        s2_product  = s2_mag * s2_gain;
    end

    // ------------------------------------------------------------------
    // Stage 3: truncated product magnitude with its sign, then saturation and mode select.
    // ------------------------------------------------------------------
    logic [2:0]  s3_channel_reg;
    logic        s3_updated_reg;
    logic [15:0] s3_width_reg;
    scale_mode_t s3_mode_reg;
    logic        s3_negative_reg;
    logic [19:0] s3_mag_reg;

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s3_channel_reg  <= s2_channel_reg;
            s3_updated_reg  <= s2_updated_reg;
            s3_width_reg    <= s2_width_reg;
            s3_mode_reg     <= s2_mode;
            s3_negative_reg <= s2_negative;
            s3_mag_reg      <= s2_product[31:Q_SHIFT];
        end
    end

    logic [15:0] s3_pos_sat;
    logic [15:0] s3_neg_sat;
    logic [15:0] s3_scaled;

    always_comb
    begin
        // Dividing the magnitude before applying the sign truncates toward zero.
        s3_pos_sat = (s3_mag_reg > 20'(POS_MAX)) ? POS_MAX : s3_mag_reg[15:0];
        s3_neg_sat = (s3_mag_reg >= 20'(NEG_MAX)) ? NEG_MAX : 16'(-s3_mag_reg[15:0]);
        case (s3_mode_reg)
            MODE_STICK:     s3_scaled = s3_negative_reg ? s3_neg_sat : s3_pos_sat;
            MODE_STICK_NEG: s3_scaled = s3_negative_reg ? s3_pos_sat : s3_neg_sat;
            MODE_THROTTLE:  s3_scaled = s3_negative_reg ? 16'd0 : s3_pos_sat;
            MODE_RAW:       s3_scaled = s3_width_reg[15] ? POS_MAX : s3_width_reg;
            default:        s3_scaled = 16'd0;
        endcase
        if (!s3_updated_reg)
        begin
            s3_scaled = 16'd0;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [2:0]  out_channel_reg;
    logic        out_updated_reg;
    logic [15:0] out_width_reg;
    logic [15:0] out_scaled_reg;

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            out_channel_reg <= s3_channel_reg;
            out_updated_reg <= s3_updated_reg;
            out_width_reg   <= s3_width_reg;
            out_scaled_reg  <= s3_scaled;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_channel  = out_channel_reg;
    assign updated      = out_updated_reg;
    assign pulse_width  = out_width_reg;
    assign scaled_value = out_scaled_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // An event that forms no width reports zeros.
    a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_updated_reg |-> out_width_reg == 16'd0 && out_scaled_reg == 16'd0)
        else $error("result without a width carries nonzero data");

    // The throttle command is never negative.
    a_throttle_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_channel_reg == 3'd4 |-> !out_scaled_reg[15])
        else $error("throttle command below zero");

    // Raw channels pass the width through, saturated to the positive range.
    a_raw_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_updated_reg && (out_channel_reg == 3'd2 || out_channel_reg == 3'd3)
        |-> out_scaled_reg == (out_width_reg[15] ? POS_MAX : out_width_reg))
        else $error("raw channel command differs from its width");

    // A middle stage that cannot move keeps its item.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_adv |=> s2_valid_reg && $stable(s2_width_reg)
            && $stable(s2_channel_reg))
        else $error("stalled pipeline stage lost its transaction");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top
    import rcpwm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // A run with no accepted transaction on either side for this many cycles is hung.
    localparam int STALL_LIMIT   = 2000;
    // Quiet cycles after the last result, well over the pipeline latency.
    localparam int DRAIN_CYCLES  = 8;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_EVENTS  = 75;
    localparam int NUM_DIRECTED  = 23;
    localparam int MAX_REPORTS   = 10;

    // One decoded result, in the order of the output ports.
    typedef struct packed {
        logic [2:0]         chan;
        logic               upd;
        logic [15:0]        width;
        logic signed [15:0] cmd;
    } pulse_result_t;

    // One capture event. When typed is set, the row also carries the result
    // that the block must return, written out by hand.
    typedef struct packed {
        logic [2:0]    chan;
        logic          level;
        logic [15:0]   cap;
        logic          typed;
        pulse_result_t exp;
    } capture_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = REG_WIDTH_LIMIT;
    logic [15:0]        cfg_data = 16'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         channel = 3'd0;
    logic               pin_level = 1'b0;
    logic [15:0]        capture_value = 16'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         out_channel;
    logic               updated;
    logic [15:0]        pulse_width;
    logic signed [15:0] scaled_value;

    rc_pwm_pulse_width_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .channel       (channel),
        .pin_level     (pin_level),
        .capture_value (capture_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_channel   (out_channel),
        .updated       (updated),
        .pulse_width   (pulse_width),
        .scaled_value  (scaled_value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the block: configuration registers, indexed by register
    // index, and the per-channel capture state.
    logic [15:0] cfg_shadow [5];
    logic [15:0] rise_t [8];
    logic [15:0] fall_t [8];
    logic [15:0] good_width [8];

    // Results still owed by the block, oldest first.
    pulse_result_t pending_results [$];

    int  fault_count = 0;
    int  stall_cycles = 0;
    // When clear, both sides run without idle cycles.
    bit  idle_on = 1'b1;

    // Directed events, run with the reset configuration (limit 1000, stick
    // offset 700, throttle offset 510). The hand-typed rows cover fall before
    // rise, a glitch replaced by the last good width, raw channels, a width
    // equal to the offset, and the throttle clamp at zero. The other rows, the
    // start-up glitch that falls back to a zero width, the inverted channel and
    // the full-range counter values among them, go through the predictor.
    capture_row_t directed_rows [NUM_DIRECTED] = '{
        '{3'd2, 1'b1, 16'd0,     1'b1, '{3'd2, 1'b1, 16'd0,    16'sd0}},
        '{3'd2, 1'b0, 16'd1000,  1'b1, '{3'd2, 1'b1, 16'd1000, 16'sd1000}},
        '{3'd2, 1'b0, 16'd1001,  1'b1, '{3'd2, 1'b1, 16'd1000, 16'sd1000}},
        '{3'd3, 1'b1, 16'hFFFF,  1'b1, '{3'd3, 1'b0, 16'd0,    16'sd0}},
        '{3'd3, 1'b0, 16'hFFFF,  1'b1, '{3'd3, 1'b1, 16'd0,    16'sd0}},
        '{3'd0, 1'b1, 16'd100,   1'b1, '{3'd0, 1'b0, 16'd0,    16'sd0}},
        '{3'd0, 1'b0, 16'd1600,  1'b0, '0},
        '{3'd0, 1'b1, 16'd1000,  1'b0, '0},
        '{3'd0, 1'b0, 16'd2700,  1'b0, '0},
        '{3'd0, 1'b0, 16'd1700,  1'b1, '{3'd0, 1'b1, 16'd700,  16'sd0}},
        '{3'd7, 1'b1, 16'd5000,  1'b1, '{3'd7, 1'b0, 16'd0,    16'sd0}},
        '{3'd7, 1'b0, 16'd5900,  1'b0, '0},
        '{3'd7, 1'b0, 16'd5700,  1'b1, '{3'd7, 1'b1, 16'd700,  16'sd0}},
        '{3'd4, 1'b1, 16'd20000, 1'b1, '{3'd4, 1'b0, 16'd0,    16'sd0}},
        '{3'd4, 1'b0, 16'd20300, 1'b1, '{3'd4, 1'b1, 16'd300,  16'sd0}},
        '{3'd4, 1'b0, 16'd21000, 1'b0, '0},
        '{3'd4, 1'b0, 16'd20510, 1'b1, '{3'd4, 1'b1, 16'd510,  16'sd0}},
        '{3'd1, 1'b1, 16'd0,     1'b0, '0},
        '{3'd1, 1'b0, 16'd1000,  1'b0, '0},
        '{3'd5, 1'b1, 16'hFF00,  1'b1, '{3'd5, 1'b0, 16'd0,    16'sd0}},
        '{3'd5, 1'b0, 16'hFFFF,  1'b0, '0},
        '{3'd6, 1'b1, 16'd0,     1'b0, '0},
        '{3'd6, 1'b0, 16'd0,     1'b0, '0}
    };

    // Computes the result of one capture event and advances the shadow state.
    function automatic pulse_result_t predict_capture(logic [2:0] ch, logic level,
                                                      logic [15:0] cap);
        pulse_result_t res;
        logic [15:0]   w;
        logic [15:0]   offset;
        logic [15:0]   gain;
        longint        diff;
        longint        mag;
        longint        prod;
        longint        cmd;

        res = '{chan: ch, upd: 1'b0, width: 16'd0, cmd: 16'sd0};
        if (level)
            rise_t[ch] = cap;
        else
            fall_t[ch] = cap;

        // A fall time before the rise time means the pulse is not complete yet.
        if (fall_t[ch] < rise_t[ch])
            return res;

        w = fall_t[ch] - rise_t[ch];
        if (w > cfg_shadow[REG_WIDTH_LIMIT])
            w = good_width[ch];
        good_width[ch] = w;

        offset = (ch == 3'd4) ? cfg_shadow[REG_THROTTLE_OFFSET] : cfg_shadow[REG_STICK_OFFSET];
        gain   = (ch == 3'd4) ? cfg_shadow[REG_THROTTLE_GAIN] : cfg_shadow[REG_STICK_GAIN];

        // Scale the magnitude so that the Q4.12 product truncates toward zero.
        diff = longint'(w) - longint'(offset);
        mag  = (diff < 0) ? -diff : diff;
        prod = (mag * longint'(gain)) >> 12;
        cmd  = (diff < 0) ? -prod : prod;

        case (ch)
            3'd2, 3'd3: cmd = longint'(w);
            3'd4:       cmd = (cmd < 0) ? 0 : cmd;
            3'd7:       cmd = -cmd;
            default:    ;
        endcase

        if (cmd > 32767)
            cmd = 32767;
        else if (cmd < -32768)
            cmd = -32768;

        res.upd   = 1'b1;
        res.width = w;
        res.cmd   = cmd[15:0];
        return res;
    endfunction

    // Offers one capture event, holding it until the block takes it, then
    // queues the result it must produce. Returns just after the accepting edge.
    task automatic send_capture(input capture_row_t row);
        pulse_result_t predicted;

        while (idle_on && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        channel       <= row.chan;
        pin_level     <= row.level;
        capture_value <= row.cap;
        do
            @(posedge clk);
        while (!in_ready);

        // The predictor runs on every row so that its state follows the block.
        predicted = predict_capture(row.chan, row.level, row.cap);
        pending_results.push_back(row.typed ? row.exp : predicted);
    endtask

    // Writes all five registers on consecutive edges while the block is idle.
    task automatic write_config(input logic [15:0] values [5]);
        for (int i = REG_WIDTH_LIMIT; i <= REG_THROTTLE_GAIN; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= values[i];
            cfg_shadow[i] = values[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // Stops offering transactions and waits for every owed result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: each accepted transaction is checked against the oldest
    // expectation, then the ready is redrawn for the next cycle.
    always @(posedge clk)
    begin
        pulse_result_t got;
        pulse_result_t want;

        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_channel, updated, pulse_width, scaled_value};
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result: ch=%0d upd=%0d width=%0d cmd=%0d",
                             got.chan, got.upd, got.width, got.cmd);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.chan !== want.chan || got.upd !== want.upd
                    || got.width !== want.width || got.cmd !== want.cmd)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                    begin
                        $write("mismatch: expected ch=%0d upd=%0d width=%0d cmd=%0d,",
                               want.chan, want.upd, want.width, want.cmd);
                        $display(" got ch=%0d upd=%0d width=%0d cmd=%0d",
                                 got.chan, got.upd, got.width, got.cmd);
                    end
                end
            end
        end
        out_ready <= !(idle_on && $urandom_range(0, 99) < 10);
    end

    // Watchdog: counts cycles in which neither side completes a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] next_cfg [5];
        int          sent;
        int          span;
        int          w;
        logic [15:0] t;
        logic [2:0]  ch;

        // The shadow starts from the reset state of the block.
        cfg_shadow[REG_WIDTH_LIMIT]     = WIDTH_LIMIT_RST;
        cfg_shadow[REG_STICK_OFFSET]    = STICK_OFFSET_RST;
        cfg_shadow[REG_STICK_GAIN]      = STICK_GAIN_RST;
        cfg_shadow[REG_THROTTLE_OFFSET] = THROTTLE_OFFSET_RST;
        cfg_shadow[REG_THROTTLE_GAIN]   = THROTTLE_GAIN_RST;
        for (int i = 0; i < 8; i++)
        begin
            rise_t[i]     = 16'd0;
            fall_t[i]     = 16'd0;
            good_width[i] = 16'd0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_capture(directed_rows[i]);

        // Random phases, each under its own configuration. The first three hit
        // the corners: everything at maximum (negative saturation), everything
        // at zero (every nonzero width a glitch, zero gain), and positive
        // saturation. Then the reset values and two random settings.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();

            for (int i = REG_WIDTH_LIMIT; i <= REG_THROTTLE_GAIN; i++)
                next_cfg[i] = 16'($urandom);
            case (phase)
                0: next_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                1: next_cfg = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
                2: next_cfg = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
                3: next_cfg = '{WIDTH_LIMIT_RST, STICK_OFFSET_RST, STICK_GAIN_RST,
                                THROTTLE_OFFSET_RST, THROTTLE_GAIN_RST};
                5: next_cfg[REG_WIDTH_LIMIT] = 16'($urandom_range(200, 3000));
                default: ;
            endcase
            write_config(next_cfg);

            // One whole phase runs with both sides always ready.
            idle_on = (phase != 2);

            sent = 0;
            while (sent < PHASE_EVENTS)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    // A complete pulse on one channel. Widths mostly lie below
                    // the glitch limit, some just above it, some exactly on it.
                    span = int'(cfg_shadow[REG_WIDTH_LIMIT]);
                    span = span + span / 4 + 1;
                    if (span > 65535)
                        span = 65535;
                    case ($urandom_range(0, 9))
                        0:       w = int'(cfg_shadow[REG_WIDTH_LIMIT]);
                        1:       w = int'(cfg_shadow[REG_WIDTH_LIMIT]) + 1;
                        default: w = $urandom_range(0, span);
                    endcase
                    ch = 3'($urandom_range(0, 7));
                    t  = 16'($urandom);
                    send_capture(capture_row_t'{ch, 1'b1, t, 1'b0, '0});
                    send_capture(capture_row_t'{ch, 1'b0, 16'(int'(t) + w), 1'b0, '0});
                    sent += 2;
                end
                else
                begin
                    // A stray edge with arbitrary content.
                    send_capture(capture_row_t'{3'($urandom_range(0, 7)), 1'($urandom),
                                                16'($urandom), 1'b0, '0});
                    sent += 1;
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
